// ===== src/mrrc_pkg.sv =====
// mrrc_pkg: shared types, codes and the crc-16 byte update for the modbus
// read response checker; no dependencies
package mrrc_pkg;

   // result kinds
   localparam logic KIND_VALUE  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // frame status codes
   localparam logic [3:0] STATUS_OK        = 4'd0;
   localparam logic [3:0] STATUS_SHORT     = 4'd1;
   localparam logic [3:0] STATUS_LENGTH    = 4'd2;
   localparam logic [3:0] STATUS_CRC       = 4'd3;
   localparam logic [3:0] STATUS_ADDRESS   = 4'd4;
   localparam logic [3:0] STATUS_FUNCTION  = 4'd5;
   localparam logic [3:0] STATUS_BYTECOUNT = 4'd6;
   localparam logic [3:0] STATUS_REGCOUNT  = 4'd7;
   localparam logic [3:0] STATUS_EXCEPTION = 4'd8;

   // configuration register indexes
   localparam logic CSR_UNIT_ADDR = 1'b0;
   localparam logic CSR_REG_QTY   = 1'b1;

   localparam logic [7:0] RESET_UNIT_ADDR = 8'd1;
   localparam logic [6:0] RESET_REG_QTY   = 7'd1;

   // protocol constants
   localparam logic [15:0] CRC_INIT  = 16'hFFFF;
   localparam logic [15:0] CRC_POLY  = 16'hA001;
   localparam logic [7:0]  FUNC_READ = 8'h03;
   localparam logic [7:0]  EXC_FLAG  = 8'h80;
   localparam logic [8:0]  MIN_LEN   = 9'd5;
   localparam logic [8:0]  POS_MAX   = 9'd511;
   localparam logic [8:0]  DATA_START = 9'd3;

   localparam int DEF_MAX_REGISTERS = 125;
   localparam int DEF_QUEUE_DEPTH   = 2;

   // one entry between front and back
   typedef struct packed {
      logic        kind;
      logic [15:0] value;
      logic [6:0]  index;
      logic        crc_ok;
      logic [7:0]  address;
      logic [7:0]  func;
      logic [7:0]  count;
      logic [8:0]  len;
   } mrrc_entry_type;

   // queue handshake: not_empty toward the back end, full toward the front end
   typedef struct packed {
      logic not_empty;
      logic full;
   } mrrc_queue_status_type;

   // crc-16/modbus, reflected, one byte
   function automatic logic [15:0] crc_update(input logic [15:0] crc,
                                              input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) c = (c >> 1) ^ CRC_POLY;
         else      c = c >> 1;
      end
      return c;
   endfunction

endpackage

// ===== src/mrrc_front.sv =====
// mrrc_front: takes frame bytes, runs the crc and frame counters and turns
// each byte that causes a result into a queue entry; uses mrrc_pkg
module mrrc_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [7:0]               req_data_byte,
   input  logic                     req_end_of_frame,
   input  logic                     queue_full,
   output logic                     push,
   output mrrc_pkg::mrrc_entry_type push_entry
);

   logic [15:0] crc_ff, crc_in;
   logic [8:0]  pos_ff, pos_in;
   logic [7:0]  addr_ff, addr_in;
   logic [7:0]  func_ff, func_in;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  pend_ff, pend_in;
   logic [6:0]  index_ff, index_in;

   logic        accept;
   logic [15:0] crc_next;
   logic [8:0]  len;
   logic        in_region;
   logic        emit;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      crc_next  = mrrc_pkg::crc_update(crc_ff, req_data_byte);
      len       = (pos_ff == mrrc_pkg::POS_MAX) ? pos_ff : pos_ff + 9'd1;
      in_region = (pos_ff >= mrrc_pkg::DATA_START) &&
                  ({1'b0, pos_ff} < {1'b0, mrrc_pkg::DATA_START} + {2'b00, count_ff});
      emit      = in_region && !pos_ff[0] && !req_end_of_frame;

      addr_in  = (pos_ff == 9'd0) ? req_data_byte : addr_ff;
      func_in  = (pos_ff == 9'd1) ? req_data_byte : func_ff;
      count_in = (pos_ff == 9'd2) ? req_data_byte : count_ff;
      crc_in   = crc_next;
      pos_in   = len;
      pend_in  = (in_region && pos_ff[0]) ? req_data_byte : pend_ff;
      index_in = emit ? index_ff + 7'd1 : index_ff;

      push_entry.kind    = req_end_of_frame ? mrrc_pkg::KIND_STATUS : mrrc_pkg::KIND_VALUE;
      push_entry.value   = {pend_ff, req_data_byte};
      push_entry.index   = index_ff;
      push_entry.crc_ok  = (crc_next == 16'h0000);
      push_entry.address = addr_in;
      push_entry.func    = func_in;
      push_entry.count   = count_in;
      push_entry.len     = len;

      push = accept && (req_end_of_frame || emit);
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req_end_of_frame)) begin
         crc_ff   <= mrrc_pkg::CRC_INIT;
         pos_ff   <= '0;
         addr_ff  <= '0;
         func_ff  <= '0;
         count_ff <= '0;
         pend_ff  <= '0;
         index_ff <= '0;
      end else if (accept) begin
         crc_ff   <= crc_in;
         pos_ff   <= pos_in;
         addr_ff  <= addr_in;
         func_ff  <= func_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
         index_ff <= index_in;
      end
   end

endmodule

// ===== src/mrrc_queue.sv =====
// mrrc_queue: short first-in first-out queue of front-end entries;
// uses mrrc_pkg for the entry type
module mrrc_queue #(
   parameter int DEPTH = mrrc_pkg::DEF_QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  mrrc_pkg::mrrc_entry_type        push_entry,
   input  logic                            pop,
   output mrrc_pkg::mrrc_entry_type        head_entry,
   output mrrc_pkg::mrrc_queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   mrrc_pkg::mrrc_entry_type mem [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      status.not_empty = (count_ff != '0);
      status.full      = (count_ff == CNT_W'(DEPTH));
      head_entry       = mem[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== src/mrrc_back.sv =====
// mrrc_back: holds the configuration, grades frame status from queue entries
// and drives the registered result channel; uses mrrc_pkg
module mrrc_back #(
   parameter int MAX_REGISTERS = mrrc_pkg::DEF_MAX_REGISTERS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic                            csr_index,
   input  logic [7:0]                      csr_write_data,
   input  mrrc_pkg::mrrc_entry_type        head_entry,
   input  mrrc_pkg::mrrc_queue_status_type status,
   output logic                            pop,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_result_kind,
   output logic [15:0]                     rsp_register_value,
   output logic [6:0]                      rsp_register_index,
   output logic [3:0]                      rsp_status_code,
   output logic [7:0]                      rsp_exc_code,
   output logic                            rsp_frame_done
);

   localparam logic [6:0] MAX_REG = 7'(MAX_REGISTERS);

   logic [7:0]  slave_addr_ff;
   logic [6:0]  reg_count_ff;

   logic        valid_ff, valid_in;
   logic        kind_ff, kind_in;
   logic [15:0] value_ff, value_in;
   logic [6:0]  index_ff, index_in;
   logic [3:0]  code_ff, code_in;
   logic [7:0]  exc_ff, exc_in;

   logic [3:0]  grade;
   logic [7:0]  grade_exc;
   logic [8:0]  expected_len;

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_addr_ff <= mrrc_pkg::RESET_UNIT_ADDR;
         reg_count_ff  <= mrrc_pkg::RESET_REG_QTY;
      end else if (csr_write_enable) begin
         case (csr_index)
            mrrc_pkg::CSR_UNIT_ADDR: slave_addr_ff <= csr_write_data;
            mrrc_pkg::CSR_REG_QTY:   reg_count_ff  <= csr_write_data[6:0];
            default: ;
         endcase
      end
   end

   // status check in fixed priority order
   always_comb begin
      expected_len = {1'b0, head_entry.count} + mrrc_pkg::MIN_LEN;
      grade_exc    = 8'h00;
      if (head_entry.len < mrrc_pkg::MIN_LEN) begin
         grade = mrrc_pkg::STATUS_SHORT;
      end else if (!head_entry.crc_ok) begin
         grade = mrrc_pkg::STATUS_CRC;
      end else if (head_entry.address != slave_addr_ff) begin
         grade = mrrc_pkg::STATUS_ADDRESS;
      end else if (head_entry.func == (mrrc_pkg::FUNC_READ | mrrc_pkg::EXC_FLAG)) begin
         if (head_entry.len != mrrc_pkg::MIN_LEN) begin
            grade = mrrc_pkg::STATUS_LENGTH;
         end else begin
            grade     = mrrc_pkg::STATUS_EXCEPTION;
            grade_exc = head_entry.count;
         end
      end else if (head_entry.func != mrrc_pkg::FUNC_READ) begin
         grade = mrrc_pkg::STATUS_FUNCTION;
      end else if (head_entry.len != expected_len) begin
         grade = mrrc_pkg::STATUS_LENGTH;
      end else if (head_entry.count == 8'h00 || head_entry.count[0]) begin
         grade = mrrc_pkg::STATUS_BYTECOUNT;
      end else if (reg_count_ff == 7'd0 || reg_count_ff > MAX_REG ||
                   head_entry.count != {reg_count_ff, 1'b0}) begin
         grade = mrrc_pkg::STATUS_REGCOUNT;
      end else begin
         grade = mrrc_pkg::STATUS_OK;
      end
   end

   always_comb begin
      pop      = status.not_empty && (!valid_ff || !rsp_stall);
      valid_in = valid_ff && rsp_stall;
      kind_in  = kind_ff;
      value_in = value_ff;
      index_in = index_ff;
      code_in  = code_ff;
      exc_in   = exc_ff;
      if (pop) begin
         valid_in = 1'b1;
         kind_in  = head_entry.kind;
         if (head_entry.kind == mrrc_pkg::KIND_STATUS) begin
            value_in = 16'h0000;
            index_in = 7'd0;
            code_in  = grade;
            exc_in   = grade_exc;
         end else begin
            value_in = head_entry.value;
            index_in = head_entry.index;
            code_in  = mrrc_pkg::STATUS_OK;
            exc_in   = 8'h00;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      value_ff <= value_in;
      index_ff <= index_in;
      code_ff  <= code_in;
      exc_ff   <= exc_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_result_kind    = kind_ff;
   assign rsp_register_value = value_ff;
   assign rsp_register_index = index_ff;
   assign rsp_status_code    = code_ff;
   assign rsp_exc_code       = exc_ff;
   assign rsp_frame_done     = (kind_ff == mrrc_pkg::KIND_STATUS);

endmodule

// ===== src/modbus_read_response_checker_unit.sv =====
// modbus_read_response_checker_unit: top level of the modbus rtu read
// holding registers response checker; uses mrrc_pkg, mrrc_front, mrrc_queue, mrrc_back
//
//   channel   direction  handshake          payload
//   req_      in         valid / stall      data_byte, end_of_frame
//   rsp_      out        valid / stall      result_kind, register_value,
//                                           register_index, status_code,
//                                           exc_code, frame_done
//   csr_      in         write_enable       index, write_data
//
// one byte per cycle while the queue is not full; the crc byte update and field
// capture sit in the front stage, so a transaction taken on req_ is written into
// the queue and then into the back's output register before it is offered on rsp_
// the front stalls only while the queue (two entries by default) is full, so rsp_stall
// reaches req_stall only through the registered queue count and never combinationally
// reset is synchronous; no clearing pass
module modbus_read_response_checker_unit #(
   parameter int MAX_REGISTERS = mrrc_pkg::DEF_MAX_REGISTERS,
   parameter int QUEUE_DEPTH   = mrrc_pkg::DEF_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // byte input
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_frame,
   // results
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic [15:0] rsp_register_value,
   output logic [6:0]  rsp_register_index,
   output logic [3:0]  rsp_status_code,
   output logic [7:0]  rsp_exc_code,
   output logic        rsp_frame_done,
   // configuration writes
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [7:0]  csr_write_data
);

   // front to queue
   logic                            push;
   mrrc_pkg::mrrc_entry_type        push_entry;
   // queue to back
   logic                            pop;
   mrrc_pkg::mrrc_entry_type        head_entry;
   mrrc_pkg::mrrc_queue_status_type queue_status;

   // front: crc, byte counter, header capture, pairing of data bytes
   mrrc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_end_of_frame (req_end_of_frame),
      .queue_full       (queue_status.full),
      .push             (push),
      .push_entry       (push_entry)
   );

   // only bytes that cause a result take a slot
   mrrc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (queue_status)
   );

   // back: status grading against the configuration and the output register
   mrrc_back #(
      .MAX_REGISTERS (MAX_REGISTERS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .head_entry         (head_entry),
      .status             (queue_status),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_register_value (rsp_register_value),
      .rsp_register_index (rsp_register_index),
      .rsp_status_code    (rsp_status_code),
      .rsp_exc_code       (rsp_exc_code),
      .rsp_frame_done     (rsp_frame_done)
   );

endmodule
